FILE: hdl/pwmdiv_pkg.sv
// ----------------------------------------------------------------------------
// pwmdiv_pkg
// Shared types and constants of the PWM divider and wrap solver.
// ----------------------------------------------------------------------------
package pwmdiv_pkg;

  // field widths
  localparam int unsigned FreqW   = 28;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned D16W    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned MulW    = 32;

  // configuration port
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // largest period count (the wrap value is one less)
  localparam logic [CountW-1:0] WRAP_LIMIT = 16'd65534;

  // source clock after reset
  localparam logic [FreqW-1:0] SRC_CLK_RESET = 28'd125000000;

  // reciprocals for exact division of 32-bit values by 5 and by 3
  localparam logic [MulW-1:0] RECIP5 = 32'hCCCC_CCCD;
  localparam logic [MulW-1:0] RECIP3 = 32'hAAAA_AAAB;

  // status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_TOO_HIGH = 2'd1;
  localparam logic [StatusW-1:0] STATUS_TOO_LOW  = 2'd2;

  // input word
  typedef struct packed {
    logic [FreqW-1:0] freq_hz;
    logic [DutyW-1:0] duty;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0]         div_integer;
    logic [3:0]         div_fraction;
    logic [CountW-1:0]  wrap_value;
    logic [CountW-1:0]  compare_level;
    logic [StatusW-1:0] status;
  } out_word_t;

endpackage

FILE: hdl/pwmdiv_serdiv.sv
// ----------------------------------------------------------------------------
// pwmdiv_serdiv
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmdiv_serdiv
  import pwmdiv_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [D16W-1:0] dividend_i,
  input  logic [FreqW-1:0] divisor_i,
  output logic            done_o,
  output logic [D16W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(D16W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [FreqW-1:0] rem_q, rem_d;
  logic [D16W-1:0] quo_q, quo_d;
  logic [FreqW-1:0] dvs_q, dvs_d;

  logic [FreqW:0]   rem_sh;
  logic [FreqW+1:0] diff;

  // one shift-and-subtract step
  always_comb begin
    rem_sh = {rem_q, quo_q[D16W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  end

  // sequencing of the iterations
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so its top bit is always clear
      if (diff[FreqW+1]) begin
        rem_d = rem_sh[FreqW-1:0];
        quo_d = {quo_q[D16W-2:0], 1'b0};
      end else begin
        rem_d = diff[FreqW-1:0];
        quo_d = {quo_q[D16W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(D16W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/pwm_divider_wrap_solver.sv
// ----------------------------------------------------------------------------
// pwm_divider_wrap_solver
// Finds the PWM clock divider, wrap value and compare level for a frequency.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one word (freq_hz, duty).
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word (div_integer, div_fraction, wrap_value, compare_level, status).
// The APB port holds source_clock_hz at byte address 0; write it only while
// the block is idle.
// Operation: a serial divide of 32 quotient bits forms
// 16*source_clock_hz/freq_hz, then a small sequencer moves factors of 5, 3
// and 2 into the period count using one shared 32x32 multiplier (reciprocal
// division for 5 and 3, each a try and a check state, the check skipped
// when the limits rule it out). The compare level, duty times period count,
// uses the same multiplier. A zero frequency skips the divide and factoring;
// the next word can enter once the sequencer is idle. One word is worked
// on at a time: in_stall_o is high from acceptance until the result is
// placed in the output register.
// The output register lets the next word enter while a result waits; if
// out_stall_i holds the previous result, the finished one waits internally.
// Reset clears all control state and sets source_clock_hz to 125 MHz.
// ----------------------------------------------------------------------------
module pwm_divider_wrap_solver
  import pwmdiv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_TRY5 = 4'd2;
  localparam logic [3:0] S_CHK5 = 4'd3;
  localparam logic [3:0] S_TRY3 = 4'd4;
  localparam logic [3:0] S_CHK3 = 4'd5;
  localparam logic [3:0] S_TRY2 = 4'd6;
  localparam logic [3:0] S_MULD = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [FreqW-1:0]  src_clk_q;
  logic [D16W-1:0]   d16_q, d16_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [2*MulW-1:0] prod_q, prod_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic              in_fire;
  logic              cfg_wr;
  logic              div_start;
  logic              div_done;
  logic [D16W-1:0]   div_quo;

  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;

  logic [CountW+2:0] count5;
  logic [CountW+1:0] count3;
  logic [CountW:0]   count2;
  logic [D16W-3:0]   q5;
  logic [D16W-2:0]   q3;
  logic [D16W-1:0]   q5x5, q3x3;
  logic [MulW:0]     cmp_sum;
  logic [StatusW-1:0] status;
  logic              out_free;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ApbAddrW-1] == 1'b0);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_clk_q <= SRC_CLK_RESET;
    end else if (cfg_wr) begin
      src_clk_q <= pwdata[FreqW-1:0];
    end
  end

  always_comb begin
    if (paddr[ApbAddrW-1] == 1'b0) begin
      prdata = {{(ApbDataW-FreqW){1'b0}}, src_clk_q};
    end else begin
      prdata = '0;
    end
  end

  // handshakes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = in_fire && (in_word_i.freq_hz != '0);

  // serial divider for 16*source_clock/freq
  pwmdiv_serdiv u_serdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({src_clk_q, 4'b0000}),
    .divisor_i  (in_word_i.freq_hz),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_TRY5: begin
        mul_a = d16_q;
        mul_b = RECIP5;
      end
      S_TRY3: begin
        mul_a = d16_q;
        mul_b = RECIP3;
      end
      default: begin
        mul_a = {{(MulW-DutyW){1'b0}}, duty_q};
        mul_b = {{(MulW-CountW){1'b0}}, count_q};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // factor arithmetic on the count and on the registered product
  always_comb begin
    count5  = {1'b0, count_q, 2'b00} + {3'b000, count_q};
    count3  = {1'b0, count_q, 1'b0} + {2'b00, count_q};
    count2  = {count_q, 1'b0};
    q5      = prod_q[2*MulW-1:34];
    q3      = prod_q[2*MulW-1:33];
    q5x5    = {q5, 2'b00} + {2'b00, q5};
    q3x3    = {q3, 1'b0} + {1'b0, q3};
    cmp_sum = {1'b0, prod_q[MulW-1:0]} + {{MulW{1'b0}}, 1'b1}
            + {{(MulW-15){1'b0}}, prod_q[MulW-1:16]};
  end

  // divider range check
  always_comb begin
    priority if (d16_q[D16W-1:4] == '0) begin
      status = STATUS_TOO_HIGH;
    end else if (d16_q[D16W-1:12] != '0) begin
      status = STATUS_TOO_LOW;
    end else begin
      status = STATUS_OK;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    d16_d       = d16_q;
    count_d     = count_q;
    duty_d      = duty_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          count_d = CountW'(1);
          duty_d  = in_word_i.duty;
          if (in_word_i.freq_hz == '0) begin
            d16_d   = '1;
            state_d = S_FIN;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          d16_d   = div_quo;
          state_d = S_TRY5;
        end
      end
      S_TRY5: begin
        if ((d16_q >= D16W'(80)) && (count5 <= (CountW+3)'(WRAP_LIMIT))) begin
          prod_d  = mul_p;
          state_d = S_CHK5;
        end else begin
          state_d = S_TRY3;
        end
      end
      S_CHK5: begin
        if (q5x5 == d16_q) begin
          d16_d   = {2'b00, q5};
          count_d = count5[CountW-1:0];
          state_d = S_TRY5;
        end else begin
          state_d = S_TRY3;
        end
      end
      S_TRY3: begin
        if ((d16_q >= D16W'(48)) && (count3 <= (CountW+2)'(WRAP_LIMIT))) begin
          prod_d  = mul_p;
          state_d = S_CHK3;
        end else begin
          state_d = S_TRY2;
        end
      end
      S_CHK3: begin
        if (q3x3 == d16_q) begin
          d16_d   = {1'b0, q3};
          count_d = count3[CountW-1:0];
          state_d = S_TRY5;
        end else begin
          state_d = S_TRY2;
        end
      end
      S_TRY2: begin
        if ((d16_q >= D16W'(32)) && (count2 <= (CountW+1)'(WRAP_LIMIT))) begin
          d16_d   = {1'b0, d16_q[D16W-1:1]};
          count_d = count2[CountW-1:0];
          state_d = S_TRY5;
        end else begin
          state_d = S_MULD;
        end
      end
      S_MULD: begin
        prod_d  = mul_p;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '0;
          out_word_d.status = status;
          if (status == STATUS_OK) begin
            out_word_d.div_integer   = d16_q[11:4];
            out_word_d.div_fraction  = d16_q[3:0];
            out_word_d.wrap_value    = count_q - CountW'(1);
            out_word_d.compare_level = cmp_sum[MulW-1:16];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    d16_q      <= d16_d;
    count_q    <= count_d;
    duty_q     <= duty_d;
    prod_q     <= prod_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // an accepted word keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // error results carry no divider, wrap or compare
  a_error_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != STATUS_OK) |->
      (out_word_o.div_integer == '0) && (out_word_o.div_fraction == '0) &&
      (out_word_o.wrap_value == '0) && (out_word_o.compare_level == '0))
    else $error("error result with nonzero fields");

  // a good result has a divider of at least one
  a_ok_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == STATUS_OK) |-> (out_word_o.div_integer != '0))
    else $error("ok result with divider below one");

  // period count stays within the wrap limit while factoring
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRY5) || (state_q == S_TRY3) || (state_q == S_TRY2) |->
      (count_q != '0) && (count_q <= WRAP_LIMIT))
    else $error("period count out of range");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("stalled result overwritten");

endmodule
